/* rtl/integer_to_ascii_padded_formatter_assert.svh */
// Assertion macros shared by the formatter checker.
`ifndef INTEGER_TO_ASCII_PADDED_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_PADDED_FORMATTER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define ITAPF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define ITAPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/itapf_pkg.sv */
// Package: types and constants of the integer to ASCII formatter.
`default_nettype none

package itapf_pkg;

    // Conversion codes
    localparam logic [2:0] MODE_SDEC = 3'd0;
    localparam logic [2:0] MODE_UDEC = 3'd1;
    localparam logic [2:0] MODE_LHEX = 3'd2;
    localparam logic [2:0] MODE_UHEX = 3'd3;
    localparam logic [2:0] MODE_PTR  = 3'd4;

    // Pad saturation limits
    localparam logic [4:0] MAX_SPACES = 5'd20;
    localparam logic [4:0] MAX_ZEROS  = 5'd20;

    // Digit register holds 16 nibbles, most significant at the top
    localparam logic [4:0] DIGIT_NIBBLES = 5'd16;
    localparam logic [4:0] DEC_BITS_LAST = 5'd31;

    // ASCII codes
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_X       = 8'h78;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_LOWER_A = 8'd97;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_NORM,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

/* rtl/integer_to_ascii_padded_formatter.sv */
// Top level: integer to ASCII formatter with space and zero padding.
// Usage:
//   Input channel (i_in_valid / o_in_stall): one request per conversion with
//   mode, 64-bit value, alignment, space and zero pad counts, digit enable.
//   Output channel (o_out_valid / i_out_stall): one ASCII character per
//   request, o_last high on the final character of a conversion. A
//   conversion that produces no characters produces no output requests.
// Timing:
//   Decimal modes run a bit-serial double-dabble (one bit of the binary value
//   per cycle), hex modes skip it. Leading zero digits are then stripped one
//   nibble per cycle. Characters follow at one per cycle while the receiver
//   does not stall. o_in_stall stays high until the last character has been
//   loaded into the output register.
// Reset (i_rst_n low, synchronous): returns to idle, drops o_out_valid.
// Stall: a stalled character holds in the output register, and character
//   generation pauses until it is taken.
`default_nettype none

module integer_to_ascii_padded_formatter import itapf_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input requests
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [2:0]  i_mode,
    input  wire logic [63:0] i_value,
    input  wire logic        i_left_align,
    input  wire logic [4:0]  i_space_count,
    input  wire logic [4:0]  i_zero_count,
    input  wire logic        i_show_digits,
    // output characters
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_char_out,
    output logic             o_last
);

    // control
    t_state      r_state, n_state;
    logic        r_ovalid, n_ovalid;
    // conversion payload
    logic [63:0] r_dig, n_dig;     // digit nibbles, top nibble printed first
    logic [31:0] r_bin, n_bin;     // binary value shifted into double-dabble
    logic [4:0]  r_cnt, n_cnt;     // double-dabble bit counter
    logic [4:0]  r_dcnt, n_dcnt;   // digits still to print
    logic [4:0]  r_sp, n_sp;       // spaces still to print
    logic [4:0]  r_zr, n_zr;       // zero pads still to print
    logic [1:0]  r_pfx, n_pfx;     // "0x" characters still to print
    logic        r_neg, n_neg;
    logic        r_left, n_left;
    logic        r_show, n_show;
    logic        r_upper, n_upper;
    logic [7:0]  r_char, n_char;
    logic        r_last, n_last;

    logic        in_acc;
    logic        out_free;
    logic        hex_mode;
    logic [31:0] mag32;
    logic [63:0] dd_adj;
    logic [5:0]  remain;
    logic [3:0]  nib;
    logic [7:0]  digit_ch;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_ovalid || !i_out_stall;
    assign hex_mode = (i_mode == MODE_LHEX) || (i_mode == MODE_UHEX) || (i_mode == MODE_PTR);
    // two's complement negate also covers the most negative value
    assign mag32    = (i_mode == MODE_SDEC && i_value[31]) ? (32'd0 - i_value[31:0])
                                                           : i_value[31:0];

    // double-dabble: add 3 to every BCD nibble of 5 or more before the shift
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            dd_adj[k*4 +: 4] = (r_dig[k*4 +: 4] >= 4'd5) ? (r_dig[k*4 +: 4] + 4'd3)
                                                         : r_dig[k*4 +: 4];
        end
    end

    // characters left in this conversion
    assign remain = {1'b0, r_sp} + {1'b0, r_zr} + {4'd0, r_pfx} + {5'd0, r_neg}
                  + (r_show ? {1'b0, r_dcnt} : 6'd0);

    assign nib      = r_dig[63:60];
    assign digit_ch = (nib <= 4'd9) ? (CH_ZERO + {4'd0, nib})
                    : ((r_upper ? CH_UPPER_A : CH_LOWER_A) + {4'd0, nib} - 8'd10);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
        r_dig   <= n_dig;
        r_bin   <= n_bin;
        r_cnt   <= n_cnt;
        r_dcnt  <= n_dcnt;
        r_sp    <= n_sp;
        r_zr    <= n_zr;
        r_pfx   <= n_pfx;
        r_neg   <= n_neg;
        r_left  <= n_left;
        r_show  <= n_show;
        r_upper <= n_upper;
        r_char  <= n_char;
        r_last  <= n_last;
    end

    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        n_dig    = r_dig;
        n_bin    = r_bin;
        n_cnt    = r_cnt;
        n_dcnt   = r_dcnt;
        n_sp     = r_sp;
        n_zr     = r_zr;
        n_pfx    = r_pfx;
        n_neg    = r_neg;
        n_left   = r_left;
        n_show   = r_show;
        n_upper  = r_upper;
        n_char   = r_char;
        n_last   = r_last;

        // a taken character frees the output register
        if (r_ovalid && !i_out_stall) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_sp    = (i_space_count > MAX_SPACES) ? MAX_SPACES : i_space_count;
                    n_zr    = (i_zero_count > MAX_ZEROS) ? MAX_ZEROS : i_zero_count;
                    n_pfx   = (i_mode == MODE_PTR) ? 2'd2 : 2'd0;
                    n_neg   = (i_mode == MODE_SDEC) && i_value[31];
                    n_left  = i_left_align;
                    n_show  = i_show_digits;
                    n_upper = (i_mode == MODE_UHEX);
                    n_dcnt  = DIGIT_NIBBLES;
                    n_cnt   = 5'd0;
                    n_bin   = mag32;
                    if (hex_mode) begin
                        n_dig   = i_value;
                        n_state = ST_NORM;
                    end else begin
                        n_dig   = 64'd0;
                        n_state = ST_CONV;
                    end
                end
            end
            ST_CONV: begin
                n_dig = {dd_adj[62:0], r_bin[31]};
                n_bin = {r_bin[30:0], 1'b0};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == DEC_BITS_LAST) begin
                    n_state = ST_NORM;
                end
            end
            ST_NORM: begin
                // strip leading zero digits, keep at least one
                if (nib == 4'd0 && r_dcnt > 5'd1) begin
                    n_dig  = {r_dig[59:0], 4'd0};
                    n_dcnt = r_dcnt - 5'd1;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (remain == 6'd0) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_ovalid = 1'b1;
                    n_last   = (remain == 6'd1);
                    if (remain == 6'd1) begin
                        n_state = ST_IDLE;
                    end
                    if (!r_left && r_sp != 5'd0) begin
                        n_char = CH_SPACE;
                        n_sp   = r_sp - 5'd1;
                    end else if (r_neg) begin
                        n_char = CH_MINUS;
                        n_neg  = 1'b0;
                    end else if (r_pfx == 2'd2) begin
                        n_char = CH_ZERO;
                        n_pfx  = 2'd1;
                    end else if (r_pfx == 2'd1) begin
                        n_char = CH_X;
                        n_pfx  = 2'd0;
                    end else if (r_zr != 5'd0) begin
                        n_char = CH_ZERO;
                        n_zr   = r_zr - 5'd1;
                    end else if (r_show && r_dcnt != 5'd0) begin
                        n_char = digit_ch;
                        n_dig  = {r_dig[59:0], 4'd0};
                        n_dcnt = r_dcnt - 5'd1;
                    end else begin
                        // only trailing spaces remain
                        n_char = CH_SPACE;
                        n_sp   = r_sp - 5'd1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_char_out  = r_char;
    assign o_last      = r_last;

endmodule

`default_nettype wire

/* rtl/itapf_checker.sv */
// Port-level checker for the formatter, bound to the top level.
`default_nettype none

`include "integer_to_ascii_padded_formatter_assert.svh"

module itapf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [7:0] o_char_out,
    input wire logic       o_last
);

    `ITAPF_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_char_out) && $stable(o_last), "stalled character changed or dropped")

    `ITAPF_ASSERT_NEXT(a_busy_after_req, i_in_valid && !o_in_stall, o_in_stall, "block not busy after accepting a request")

    `ITAPF_ASSERT_NEXT(a_chars_back_to_back, o_out_valid && !o_last && !i_out_stall, o_out_valid, "gap inside a conversion's characters")

    `ITAPF_ASSERT_NOW(a_idle_pending_last, !o_in_stall && o_out_valid, o_last, "idle with a non-final character pending")

endmodule

bind integer_to_ascii_padded_formatter itapf_checker u_itapf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_char_out  (o_char_out),
    .o_last      (o_last)
);

`default_nettype wire
